// ===== rtl/rnd_pkg.sv =====
// Shared constants and types for the roman numeral decoder.
`timescale 1ns / 1ps

package rnd_pkg;

    // accumulator width (signed), valid range 12..64
    localparam int ACC_WIDTH  = 32;
    localparam int SUM_W      = ACC_WIDTH + 1;
    localparam int WIDE_W     = 65;
    // signed delta per word: covers -1000 .. +2000
    localparam int DELTA_W    = 13;
    localparam int VALUE_W    = 31;
    localparam int TIER_W     = 3;
    localparam int RUN_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [TIER_W-1:0] TOP_TIER  = 3'd6;
    localparam logic [RUN_W-1:0]  RUN_LIMIT = 3'd3;
    localparam logic [RUN_W-1:0]  RUN_MAX   = 3'd4;
    localparam logic signed [WIDE_W-1:0] OUT_MAX = 65'sd2147483647;

    typedef logic signed [DELTA_W-1:0] delta_t;

    // word handed from the front to the back
    typedef struct packed {
        logic   end_flag;  // end of string: back emits a result
        logic   err;       // numeral broke a rule (end words only)
        delta_t delta;     // signed amount added to the accumulator
    } rnd_word_t;

endpackage

// ===== rtl/roman_numeral_decoder_core.sv =====
// An end word is stored in the queue, then its result in the result register.
// One input word per cycle unless the queue is full; character words produce no output.
// A 4-deep queue separates the front decision logic from the accumulator.
// s_tready drops only when that queue is full behind a stalled result.
// Reset (rst_n, async, active low) clears lookahead, run count, accumulator and flags.
`timescale 1ns / 1ps

module roman_numeral_decoder_core
    import rnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] action (0 char, 1 end of string)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [30:0] value, [31] invalid, [32] saturated, zero above
);

    logic               in_fire;
    logic               push;
    rnd_word_t          push_word;
    logic               full;
    logic               q_valid;
    rnd_word_t          q_word;
    logic               q_pop;
    logic [VALUE_W-1:0] out_value;
    logic               out_invalid;
    logic               out_saturated;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    rnd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_end    (s_tuser),
        .in_char   (s_tdata),
        .push      (push),
        .push_word (push_word)
    );

    rnd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop_valid (q_valid),
        .pop_word  (q_word),
        .pop       (q_pop)
    );

    rnd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (q_valid),
        .word          (q_word),
        .word_pop      (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_value     (out_value),
        .out_invalid   (out_invalid),
        .out_saturated (out_saturated)
    );

    assign m_tdata = {7'd0, out_saturated, out_invalid, out_value};

endmodule

// ===== rtl/rnd_front.sv =====
// Front end: symbol lookup, run tracking, lookahead and add/subtract decision.
`timescale 1ns / 1ps

module rnd_front
    import rnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_end,
    input  logic [7:0]        in_char,
    output logic              push,
    output rnd_word_t         push_word
);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_ERR
    } op_t;

    logic [TIER_W-1:0] p0_reg, p0_next;
    logic [TIER_W-1:0] p1_reg, p1_next;
    logic [1:0]        count_reg, count_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              err_reg, err_next;

    logic              sym_ok;
    logic [TIER_W-1:0] tier;
    logic [TIER_W-1:0] last_tier;
    logic              same_run;
    logic [RUN_W-1:0]  run_new;
    op_t               op_char;
    op_t               op_end;
    delta_t            v0;
    delta_t            v1;
    delta_t            end_delta;
    logic              end_err;

    // symbol lookup, case-sensitive
    function automatic logic [TIER_W:0] lookup(input logic [7:0] code);
        logic [TIER_W:0] r;
        unique case (code)
            8'h49:   r = {1'b1, 3'd0};  // I
            8'h56:   r = {1'b1, 3'd1};  // V
            8'h58:   r = {1'b1, 3'd2};  // X
            8'h4C:   r = {1'b1, 3'd3};  // L
            8'h43:   r = {1'b1, 3'd4};  // C
            8'h44:   r = {1'b1, 3'd5};  // D
            8'h4D:   r = {1'b1, 3'd6};  // M
            default: r = {1'b0, 3'd0};
        endcase
        return r;
    endfunction

    function automatic delta_t sym_value(input logic [TIER_W-1:0] t);
        delta_t r;
        unique case (t)
            3'd0:    r = 13'sd1;
            3'd1:    r = 13'sd5;
            3'd2:    r = 13'sd10;
            3'd3:    r = 13'sd50;
            3'd4:    r = 13'sd100;
            3'd5:    r = 13'sd500;
            default: r = 13'sd1000;
        endcase
        return r;
    endfunction

    // decide one symbol from its successor and the one after
    function automatic op_t decide(input logic [TIER_W-1:0] cur,
                                   input logic [TIER_W-1:0] nxt,
                                   input logic              has_after,
                                   input logic [TIER_W-1:0] after);
        logic [TIER_W:0] c1;
        logic [TIER_W:0] c2;
        op_t             r;
        c1 = {1'b0, cur} + 4'd1;
        c2 = {1'b0, cur} + 4'd2;
        priority if (((c1 == {1'b0, nxt}) || (c2 == {1'b0, nxt})) && !cur[0])
            r = OP_SUB;
        else if (cur > nxt)
            r = OP_ADD;
        else if (cur == nxt)
            r = (has_after && (after > nxt)) ? OP_ERR : OP_ADD;
        else
            r = OP_ERR;
        return r;
    endfunction

    assign {sym_ok, tier} = lookup(in_char);
    assign last_tier = (count_reg == 2'd2) ? p1_reg : p0_reg;
    assign same_run  = (count_reg != 2'd0) && (last_tier == tier);
    assign run_new   = same_run ? ((run_reg >= RUN_MAX) ? RUN_MAX : run_reg + 3'd1) : 3'd1;
    assign op_char   = decide(p0_reg, p1_reg, 1'b1, tier);
    assign op_end    = decide(p0_reg, p1_reg, 1'b0, 3'd0);
    assign v0        = sym_value(p0_reg);
    assign v1        = sym_value(p1_reg);

    // end of string: fold the last one or two decisions into one delta
    always_comb
    begin
        end_err   = err_reg;
        end_delta = '0;
        unique case (count_reg)
            2'd0:    end_delta = '0;
            2'd1:    end_delta = v0;
            default:
            begin
                end_delta = ((op_end == OP_SUB) ? -v0 : v0) + v1;
                if (op_end == OP_ERR)
                    end_err = 1'b1;
            end
        endcase
    end

    // next state and the word pushed to the queue
    always_comb
    begin
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        err_next       = err_reg;
        push           = 1'b0;
        push_word      = '0;
        if (in_fire)
        begin
            if (in_end)
            begin
                push               = 1'b1;
                push_word.end_flag = 1'b1;
                push_word.err      = end_err;
                push_word.delta    = end_err ? '0 : end_delta;
                p0_next            = '0;
                p1_next            = '0;
                count_next         = 2'd0;
                run_next           = '0;
                err_next           = 1'b0;
            end
            else if (!err_reg)
            begin
                if (!sym_ok)
                    err_next = 1'b1;
                else
                begin
                    run_next = run_new;
                    if ((run_new > RUN_LIMIT) && (tier != TOP_TIER))
                        err_next = 1'b1;
                    else if (count_reg == 2'd2)
                    begin
                        unique case (op_char)
                            OP_ADD:
                            begin
                                push            = 1'b1;
                                push_word.delta = v0;
                            end
                            OP_SUB:
                            begin
                                push            = 1'b1;
                                push_word.delta = -v0;
                            end
                            default: err_next = 1'b1;
                        endcase
                        p0_next = p1_reg;
                        p1_next = tier;
                    end
                    else if (count_reg == 2'd1)
                    begin
                        p1_next    = tier;
                        count_next = 2'd2;
                    end
                    else
                    begin
                        p0_next    = tier;
                        count_next = 2'd1;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg    <= '0;
            p1_reg    <= '0;
            count_reg <= 2'd0;
            run_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/rnd_fifo.sv =====
// Short queue of decision words between front and back.
`timescale 1ns / 1ps

module rnd_fifo
    import rnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rnd_word_t push_word,
    output logic      full,
    output logic      pop_valid,
    output rnd_word_t pop_word,
    input  logic      pop
);

    rnd_word_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_word  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/rnd_back.sv =====
// Back end: saturating accumulator and result register.
`timescale 1ns / 1ps

module rnd_back
    import rnd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    input  rnd_word_t          word,
    output logic               word_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_invalid,
    output logic               out_saturated
);

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic                        clamp_reg, clamp_next;
    logic                        out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]          out_value_reg, out_value_next;
    logic                        out_inv_reg, out_inv_next;
    logic                        out_sat_reg, out_sat_next;

    logic signed [SUM_W-1:0]     sum;
    logic                        ovf;
    logic signed [ACC_WIDTH-1:0] acc_sat;
    logic signed [WIDE_W-1:0]    acc_wide;
    logic                        is_neg;
    logic                        is_big;

    // a plain word never waits; an end word waits for the result register
    assign word_pop = word_valid && (!word.end_flag || !out_valid_reg || out_ready);

    // saturating add of the signed delta
    assign sum      = SUM_W'(acc_reg) + SUM_W'(word.delta);
    assign ovf      = sum[SUM_W-1] ^ sum[SUM_W-2];
    assign acc_sat  = ovf ? (sum[SUM_W-1] ? ACC_MIN : ACC_MAX) : sum[ACC_WIDTH-1:0];
    assign acc_wide = WIDE_W'(acc_sat);
    assign is_neg   = acc_sat[ACC_WIDTH-1];
    assign is_big   = acc_wide > OUT_MAX;

    always_comb
    begin
        acc_next       = acc_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_inv_next   = out_inv_reg;
        out_sat_next   = out_sat_reg;
        if (word_pop)
        begin
            if (word.end_flag)
            begin
                acc_next       = '0;
                clamp_next     = 1'b0;
                out_valid_next = 1'b1;
                out_inv_next   = word.err;
                priority if (word.err)
                begin
                    out_value_next = '0;
                    out_sat_next   = 1'b0;
                end
                else if (is_neg)
                begin
                    out_value_next = '0;
                    out_sat_next   = 1'b1;
                end
                else if (is_big)
                begin
                    out_value_next = VALUE_W'(OUT_MAX);
                    out_sat_next   = 1'b1;
                end
                else
                begin
                    out_value_next = VALUE_W'(acc_sat);
                    out_sat_next   = clamp_reg | ovf;
                end
            end
            else
            begin
                acc_next   = acc_sat;
                clamp_next = clamp_reg | ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clamp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            clamp_reg     <= clamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_inv_reg   <= out_inv_next;
        out_sat_reg   <= out_sat_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_invalid   = out_inv_reg;
    assign out_saturated = out_sat_reg;

endmodule

// ===== rtl/rnd_checker.sv =====
// Port-level assertions for the roman numeral decoder, bound to the top level.
`timescale 1ns / 1ps

module rnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // invalid result carries zero value and no saturation
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[31] |-> (m_tdata[30:0] == 31'd0) && !m_tdata[32])
        else $error("invalid result with nonzero value or saturation");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:33] == 7'd0))
        else $error("result padding not zero");

    // input backpressure only follows a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule

bind roman_numeral_decoder_core rnd_checker u_rnd_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the roman numeral decoder: per-numeral prediction and streamed checks.
`timescale 1ns / 1ps

module tb_top;
    import rnd_pkg::*;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam int TIER_I = 0;
    localparam int TIER_V = 1;
    localparam int TIER_X = 2;
    localparam int TIER_L = 3;
    localparam int TIER_C = 4;
    localparam int TIER_D = 5;
    localparam int TIER_M = 6;
    localparam int NO_TIER = -1;

    localparam int ITEM_TARGET = 1250;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic       action;
        logic [7:0] code;
    } char_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               invalid;
        logic               saturated;
    } numeral_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
    logic        s_tuser = 1'b0;    // [0] action (0 char, 1 end of string)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [30:0] value, [31] invalid, [32] saturated

    char_word_t      word_q[$];
    numeral_result_t result_q[$];
    logic [7:0]      numeral_txt[$];
    char_word_t      next_word;

    int items_queued = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // decoder shadow state
    int     pend_tier[2];
    int     pend_cnt;
    int     run_len;
    longint acc;
    bit     err_flag;
    bit     clamp_flag;

    roman_numeral_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic int tier_of_code(logic [7:0] c);
        case (c)
            "I": return TIER_I;
            "V": return TIER_V;
            "X": return TIER_X;
            "L": return TIER_L;
            "C": return TIER_C;
            "D": return TIER_D;
            "M": return TIER_M;
            default: return NO_TIER;
        endcase
    endfunction

    function automatic longint tier_weight(int t);
        case (t)
            TIER_I: return 1;
            TIER_V: return 5;
            TIER_X: return 10;
            TIER_L: return 50;
            TIER_C: return 100;
            TIER_D: return 500;
            default: return 1000;
        endcase
    endfunction

    function automatic logic [7:0] tier_char(int t);
        case (t)
            TIER_I: return "I";
            TIER_V: return "V";
            TIER_X: return "X";
            TIER_L: return "L";
            TIER_C: return "C";
            TIER_D: return "D";
            default: return "M";
        endcase
    endfunction

    function automatic longint acc_limit_hi();
        return longint'(64'h7FFF_FFFF_FFFF_FFFF >> (64 - ACC_WIDTH));
    endfunction

    task automatic clear_numeral();
        pend_tier[0] = 0;
        pend_tier[1] = 0;
        pend_cnt = 0;
        run_len = 0;
        acc = 0;
        err_flag = 1'b0;
        clamp_flag = 1'b0;
    endtask

    task automatic acc_add(longint v);
        longint hi;
        hi = acc_limit_hi();
        if (acc > hi - v)
        begin
            acc = hi;
            clamp_flag = 1'b1;
        end
        else
            acc = acc + v;
    endtask

    task automatic acc_sub(longint v);
        longint lo;
        lo = -acc_limit_hi() - 1;
        if (acc < lo + v)
        begin
            acc = lo;
            clamp_flag = 1'b1;
        end
        else
            acc = acc - v;
    endtask

    // settle one symbol once its successor (and maybe the one after) is known
    task automatic settle_symbol(int cur, int nxt, bit has_after, int after);
        longint w;
        w = tier_weight(cur);
        if ((cur + 1 == nxt || cur + 2 == nxt) && (cur % 2) == 0)
            acc_sub(w);
        else if (cur > nxt)
            acc_add(w);
        else if (cur == nxt)
        begin
            if (has_after && after > nxt)
                err_flag = 1'b1;
            else
                acc_add(w);
        end
        else
            err_flag = 1'b1;
    endtask

    task automatic close_numeral();
        numeral_result_t r;
        r = '0;
        if (!err_flag)
        begin
            if (pend_cnt >= 2)
            begin
                settle_symbol(pend_tier[0], pend_tier[1], 1'b0, 0);
                settle_symbol(pend_tier[1], 0, 1'b0, 0);
            end
            else if (pend_cnt == 1)
                settle_symbol(pend_tier[0], 0, 1'b0, 0);
        end
        r.invalid = err_flag;
        if (!err_flag)
        begin
            r.saturated = clamp_flag;
            if (acc < 0)
                r.saturated = 1'b1;
            else if (acc > 64'sd2147483647)
            begin
                r.value = '1;
                r.saturated = 1'b1;
            end
            else
                r.value = acc[VALUE_W-1:0];
        end
        result_q.push_back(r);
        clear_numeral();
    endtask

    // advance the shadow decoder by one accepted word
    task automatic track_word(logic action, logic [7:0] code);
        int t;
        if (action == ACT_END)
        begin
            close_numeral();
            return;
        end
        if (err_flag)
            return;
        t = tier_of_code(code);
        if (t == NO_TIER)
        begin
            err_flag = 1'b1;
            return;
        end
        if (pend_cnt > 0 && pend_tier[pend_cnt-1] == t)
            run_len = (run_len >= RUN_MAX) ? RUN_MAX : run_len + 1;
        else
            run_len = 1;
        if (run_len > RUN_LIMIT && t != TOP_TIER)
        begin
            err_flag = 1'b1;
            return;
        end
        if (pend_cnt >= 2)
        begin
            settle_symbol(pend_tier[0], pend_tier[1], 1'b1, t);
            pend_tier[0] = pend_tier[1];
            pend_tier[1] = t;
        end
        else
        begin
            pend_tier[pend_cnt] = t;
            pend_cnt++;
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(logic [39:0] word);
        numeral_result_t want;
        if (result_q.size() == 0)
        begin
            report_mismatch("unexpected result word, value", word[30:0], -1);
            return;
        end
        want = result_q.pop_front();
        if (word[30:0] != want.value)
            report_mismatch("value", word[30:0], want.value);
        if (word[31] != want.invalid)
            report_mismatch("invalid", word[31], want.invalid);
        if (word[32] != want.saturated)
            report_mismatch("saturated", word[32], want.saturated);
        if (word[39:33] != '0)
            report_mismatch("pad bits", word[39:33], 0);
    endtask

    // ---------------- stimulus ----------------

    task automatic push_word(logic action, logic [7:0] code);
        char_word_t w;
        w.action = action;
        w.code = code;
        word_q.push_back(w);
        items_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(ACT_CHAR, s[i]);
        push_word(ACT_END, 8'($urandom_range(255)));
    endtask

    task automatic append_digit(int d, logic [7:0] one, logic [7:0] five, logic [7:0] ten);
        case (d)
            1, 2, 3: repeat (d) numeral_txt.push_back(one);
            4:
            begin
                numeral_txt.push_back(one);
                numeral_txt.push_back(five);
            end
            5, 6, 7, 8:
            begin
                numeral_txt.push_back(five);
                repeat (d - 5) numeral_txt.push_back(one);
            end
            9:
            begin
                numeral_txt.push_back(one);
                numeral_txt.push_back(ten);
            end
            default: ;
        endcase
    endtask

    // canonical spelling of n, appended to the scratch text
    task automatic append_roman(int n);
        repeat (n / 1000) numeral_txt.push_back("M");
        append_digit((n / 100) % 10, "C", "D", "M");
        append_digit((n / 10) % 10, "X", "L", "C");
        append_digit(n % 10, "I", "V", "X");
    endtask

    task automatic add_random_numeral();
        int kind;
        int pos;
        logic [7:0] tmp;
        numeral_txt = {};
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            // well formed, sometimes with a long run of thousands
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(6, 1)) numeral_txt.push_back("M");
            append_roman(($urandom_range(3) == 0) ? $urandom_range(3999, 1)
                                                  : $urandom_range(40, 1));
        end
        else if (kind < 70)
        begin
            // random symbol strings, biased toward runs
            repeat ($urandom_range(8, 1))
            begin
                if (numeral_txt.size() > 0 && $urandom_range(2) == 0)
                    numeral_txt.push_back(numeral_txt[numeral_txt.size()-1]);
                else
                    numeral_txt.push_back(tier_char($urandom_range(TIER_M)));
            end
        end
        else if (kind < 85)
        begin
            // well formed with one corrupted spot
            append_roman($urandom_range(3999, 1));
            pos = $urandom_range(numeral_txt.size() - 1);
            case ($urandom_range(2))
                0: numeral_txt[pos] = 8'($urandom_range(255));
                1: numeral_txt[pos] = numeral_txt[pos] | 8'h20;
                default:
                    if (pos > 0)
                    begin
                        tmp = numeral_txt[pos];
                        numeral_txt[pos] = numeral_txt[pos-1];
                        numeral_txt[pos-1] = tmp;
                    end
            endcase
        end
        else if (kind < 95)
            repeat ($urandom_range(4, 1)) numeral_txt.push_back(8'($urandom_range(255)));
        foreach (numeral_txt[i])
            push_word(ACT_CHAR, numeral_txt[i]);
        push_word(ACT_END, 8'($urandom_range(255)));
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_word(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.code;
                    s_tuser <= next_word.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- sequence ----------------

    task automatic run_phase(int idle_pct, int stall_pct, int upto);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_queued < upto)
            add_random_numeral();
        while (word_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_numeral();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty string, subtraction, kept quirks, run limit,
        // unknown character then ignored tail, code zero, equal-then-larger
        push_word(ACT_END, 8'hFF);
        push_text("IV");
        push_text("VV");
        push_text("IXX");
        push_text("IIII");
        push_text("aI");
        push_word(ACT_CHAR, 8'h00);
        push_word(ACT_END, 8'h00);
        push_text("IIX");

        run_phase(0, 0, ITEM_TARGET / 4);
        run_phase(53, 0, ITEM_TARGET / 2);
        run_phase(0, 53, (ITEM_TARGET * 3) / 4);
        run_phase(18, 18, ITEM_TARGET);

        while (word_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
